### hw/rtl/khb_pkg.sv
// shared types and constants for the keyed half blend pixel unit
package khb_pkg;

    // pixel mode codes
    localparam logic [2:0] MODE_555   = 3'd0;
    localparam logic [2:0] MODE_565   = 3'd1;
    localparam logic [2:0] MODE_GEN16 = 3'd2;
    localparam logic [2:0] MODE_24    = 3'd3;
    localparam logic [2:0] MODE_32    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
    localparam logic [2:0] REG_COLOR_KEY  = 3'd1;
    localparam logic [2:0] REG_RED_MASK   = 3'd2;
    localparam logic [2:0] REG_GREEN_MASK = 3'd3;
    localparam logic [2:0] REG_BLUE_MASK  = 3'd4;

    // register reset values
    localparam logic [15:0] RED_MASK_RST   = 16'hF800;
    localparam logic [15:0] GREEN_MASK_RST = 16'h07E0;
    localparam logic [15:0] BLUE_MASK_RST  = 16'h001F;

    // fixed blend masks, low bit of every channel cleared
    localparam logic [15:0] MASK_555     = 16'h7BDE;
    localparam logic [15:0] MASK_565     = 16'hF7DE;
    localparam logic [15:0] MASK_24_LO   = 16'hFEFE;
    localparam logic [15:0] MASK_24_HI   = 16'h00FE;

    localparam int LANE_W = 16;
    localparam int CFG_W  = 24;

    // operands of one 16-bit lane
    typedef struct packed {
        logic [LANE_W-1:0] src;
        logic [LANE_W-1:0] tgt;
        logic [LANE_W-1:0] key;
        logic [LANE_W-1:0] mask;
    } t_lane_in;

    // what one lane found
    typedef struct packed {
        logic [LANE_W-1:0] blend;
        logic              match;
    } t_lane_out;

    // control carried alongside the lane results
    typedef struct packed {
        logic [2:0] mode;
        logic       single;
    } t_ctrl;

    // channel mask with its lowest bit of every channel cleared
    function automatic logic [LANE_W-1:0] chan_mask(input logic [LANE_W-1:0] c);
        chan_mask = c & {c[LANE_W-2:0], 1'b0};
    endfunction

endpackage

### hw/rtl/khb_lane.sv
// one 16-bit blend lane: masked halve and add, plus color key compare
module khb_lane (
    input  khb_pkg::t_lane_in  i_lane,
    output khb_pkg::t_lane_out o_lane
);

    logic [khb_pkg::LANE_W-1:0] w_tgt_half;
    logic [khb_pkg::LANE_W-1:0] w_src_half;

    // halve both masked operands, no carry crosses a channel
    assign w_tgt_half = (i_lane.tgt & i_lane.mask) >> 1;
    assign w_src_half = (i_lane.src & i_lane.mask) >> 1;

    assign o_lane.blend = w_tgt_half + w_src_half;
    assign o_lane.match = (i_lane.src == i_lane.key);

endmodule

### hw/rtl/khb_merge.sv
// merge of the two lane results into the output word and write enables
module khb_merge (
    input  khb_pkg::t_ctrl     i_ctrl,
    input  logic [31:0]        i_target,
    input  khb_pkg::t_lane_out i_lo,
    input  khb_pkg::t_lane_out i_hi,
    output logic [31:0]        o_word,
    output logic [1:0]         o_we,
    output logic               o_err
);

    logic w_is16;
    logic w_is24;
    logic w_keyed24;
    logic w_hi_write;

    assign w_is16     = (i_ctrl.mode <= khb_pkg::MODE_GEN16);
    assign w_is24     = (i_ctrl.mode == khb_pkg::MODE_24) || (i_ctrl.mode == khb_pkg::MODE_32);
    // wide pixel is keyed only when both lanes match
    assign w_keyed24  = i_lo.match & i_hi.match;
    assign w_hi_write = !i_ctrl.single && !i_hi.match;

    // select per mode
    always_comb begin
        o_word = '0;
        o_we   = '0;
        o_err  = 1'b0;
        if (w_is16) begin
            o_word[15:0]  = i_lo.match ? i_target[15:0] : i_lo.blend;
            o_word[31:16] = w_hi_write ? i_hi.blend : i_target[31:16];
            o_we          = {w_hi_write, !i_lo.match};
        end else if (w_is24) begin
            o_word = w_keyed24 ? {8'h00, i_target[23:0]} : {8'h00, i_hi.blend[7:0], i_lo.blend};
            o_we   = {1'b0, !w_keyed24};
        end else begin
            o_err = 1'b1;
        end
    end

endmodule

### hw/rtl/keyed_half_blend_pixels_unit.sv
// top level of the keyed half blend pixel unit
// Blends one 32-bit source word over one target word at 50 percent and
// drops pixels equal to the color key through per-pixel write enables.
// A new word is taken every cycle (busy never rises); each result appears
// on the o_ ports with o_strobe once its start transfer has passed the
// register stage after the two 16-bit blend lanes and the one after the
// merge. The receiver cannot stall, so results must be taken as they come.
// Configuration writes take effect at the next edge and belong only in idle
// periods.
module keyed_half_blend_pixels_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_source_word,
    input  logic [31:0] i_target_word,
    input  logic        i_single_pixel,
    output logic        o_strobe,
    output logic [31:0] o_blended_word,
    output logic [1:0]  o_write_enables,
    output logic        o_mode_error,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [khb_pkg::CFG_W-1:0] i_cfg_data
);

    logic [2:0]  r_pixel_mode;
    logic [23:0] r_color_key;
    logic [15:0] r_red_mask;
    logic [15:0] r_green_mask;
    logic [15:0] r_blue_mask;

    logic               w_accept;
    logic               w_wide;
    logic [15:0]        w_mask16;
    khb_pkg::t_lane_in  w_lo_in;
    khb_pkg::t_lane_in  w_hi_in;
    khb_pkg::t_lane_out w_lo_out;
    khb_pkg::t_lane_out w_hi_out;

    logic               r_s1_valid;
    khb_pkg::t_ctrl     r_s1_ctrl;
    logic [31:0]        r_s1_target;
    khb_pkg::t_lane_out r_s1_lo;
    khb_pkg::t_lane_out r_s1_hi;

    logic [31:0] w_word;
    logic [1:0]  w_we;
    logic        w_err;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= khb_pkg::MODE_555;
            r_color_key  <= '0;
            r_red_mask   <= khb_pkg::RED_MASK_RST;
            r_green_mask <= khb_pkg::GREEN_MASK_RST;
            r_blue_mask  <= khb_pkg::BLUE_MASK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                khb_pkg::REG_PIXEL_MODE: r_pixel_mode <= i_cfg_data[2:0];
                khb_pkg::REG_COLOR_KEY:  r_color_key  <= i_cfg_data[23:0];
                khb_pkg::REG_RED_MASK:   r_red_mask   <= i_cfg_data[15:0];
                khb_pkg::REG_GREEN_MASK: r_green_mask <= i_cfg_data[15:0];
                khb_pkg::REG_BLUE_MASK:  r_blue_mask  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // blend mask for the 16-bit modes
    always_comb begin
        case (r_pixel_mode)
            khb_pkg::MODE_555: w_mask16 = khb_pkg::MASK_555;
            khb_pkg::MODE_565: w_mask16 = khb_pkg::MASK_565;
            default: w_mask16 = khb_pkg::chan_mask(r_red_mask)
                              | khb_pkg::chan_mask(r_green_mask)
                              | khb_pkg::chan_mask(r_blue_mask);
        endcase
    end

    assign w_wide = (r_pixel_mode == khb_pkg::MODE_24) || (r_pixel_mode == khb_pkg::MODE_32);

    // lane operands: two pixels, or bytes 1..0 and byte 2 of a wide pixel
    always_comb begin
        w_lo_in.src  = i_source_word[15:0];
        w_lo_in.tgt  = i_target_word[15:0];
        w_lo_in.key  = r_color_key[15:0];
        w_lo_in.mask = w_wide ? khb_pkg::MASK_24_LO : w_mask16;
        if (w_wide) begin
            w_hi_in.src  = {8'h00, i_source_word[23:16]};
            w_hi_in.tgt  = {8'h00, i_target_word[23:16]};
            w_hi_in.key  = {8'h00, r_color_key[23:16]};
            w_hi_in.mask = khb_pkg::MASK_24_HI;
        end else begin
            w_hi_in.src  = i_source_word[31:16];
            w_hi_in.tgt  = i_target_word[31:16];
            w_hi_in.key  = r_color_key[15:0];
            w_hi_in.mask = w_mask16;
        end
    end

    khb_lane u_lane_lo (
        .i_lane (w_lo_in),
        .o_lane (w_lo_out)
    );

    khb_lane u_lane_hi (
        .i_lane (w_hi_in),
        .o_lane (w_hi_out)
    );

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ctrl.mode   <= r_pixel_mode;
            r_s1_ctrl.single <= i_single_pixel;
            r_s1_target      <= i_target_word;
            r_s1_lo          <= w_lo_out;
            r_s1_hi          <= w_hi_out;
        end
    end

    khb_merge u_merge (
        .i_ctrl   (r_s1_ctrl),
        .i_target (r_s1_target),
        .i_lo     (r_s1_lo),
        .i_hi     (r_s1_hi),
        .o_word   (w_word),
        .o_we     (w_we),
        .o_err    (w_err)
    );

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_s1_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            o_blended_word  <= w_word;
            o_write_enables <= w_we;
            o_mode_error    <= w_err;
        end
    end

    // invalid mode writes nothing and returns a zero word
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_mode_error |-> (o_write_enables == 2'b00) && (o_blended_word == 32'h0))
        else $error("mode error with writes enabled");

    // every start transfer gives a result strobe after both register stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe)
        else $error("result strobe missing after start");

    // the high pixel enable only exists in 16-bit modes
    a_hi_we_16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_write_enables[1] |-> $past(r_s1_ctrl.mode) <= khb_pkg::MODE_GEN16)
        else $error("high pixel enable outside 16-bit modes");

endmodule
